FILE: rtl/omni_robot_feedback_drive_core_assert.svh
// assertion macros used by the checker file of the drive core
`ifndef OMNI_ROBOT_FEEDBACK_DRIVE_CORE_ASSERT_SVH
`define OMNI_ROBOT_FEEDBACK_DRIVE_CORE_ASSERT_SVH

// same-cycle implication, off while aresetn is low
`define ORFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while aresetn is low
`define ORFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/orfd_pkg.sv
// shared types, codes and constants of the omni robot drive core
package orfd_pkg;

    localparam int POS_BITS_DEF  = 16;
    localparam int DUTY_BITS_DEF = 8;

    localparam int KIND_W = 3;
    localparam int VEL_W  = 8;
    localparam int HEAD_W = 9;
    localparam int ERR_W  = 8;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int MODE_W = 2;
    localparam int ACT_W  = 2;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_FEEDBACK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FWD      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CCW      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CW       = 3'd3;

    // wheel modes
    localparam logic [MODE_W-1:0] MODE_BRAKE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REV   = 2'd2;

    // actions
    localparam logic [ACT_W-1:0] ACT_STOP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FWD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CCW  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CW   = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_DIST_THR = 3'd0;
    localparam logic [IDX_W-1:0] REG_ANG_THR  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BASE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROT_CAP  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FWD_CAP  = 3'd4;

    // register reset values
    localparam logic [15:0] DIST_THR_RST = 16'd100;
    localparam logic [7:0]  ANG_THR_RST  = 8'd10;
    localparam logic [7:0]  BASE_RST     = 8'd50;
    localparam logic [7:0]  ROT_CAP_RST  = 8'd150;
    localparam logic [7:0]  FWD_CAP_RST  = 8'd250;

    // heading arithmetic
    localparam logic [HEAD_W-1:0] FULL_TURN = 9'd360;
    localparam logic [HEAD_W-1:0] HALF_TURN = 9'd180;

    // rotate gain 72/100: x/100 as x*5243 >> 19, exact for x below 12960+1
    localparam int ROT_GAIN   = 72;
    localparam int DIV100_MUL = 5243;
    localparam int DIV100_SH  = 19;

    // forward gain 2/5: x/5 as x*1639 >> 13, exact for x below 2730
    localparam int DIV5_MUL = 1639;
    localparam int DIV5_SH  = 13;
    // distances from here on saturate any forward cap of eight bits
    localparam int DIST_CLAMP_W = 10;

    typedef struct packed {
        logic [15:0] dist_thr;
        logic [7:0]  ang_thr;
        logic [7:0]  base;
        logic [7:0]  rot_cap;
        logic [7:0]  fwd_cap;
    } cfg_t;

    // per-request data that rides along the root chain
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VEL_W-1:0]  velocity;
        logic [ERR_W-1:0]  err;
        logic [ERR_W-1:0]  rot_extra;
        logic              cw;
    } side_t;

    function automatic logic [HEAD_W-1:0] heading_norm(input logic [HEAD_W-1:0] h);
        return (h >= FULL_TURN) ? h - FULL_TURN : h;
    endfunction

endpackage

FILE: rtl/orfd_front.sv
// front end: position differences, squares and heading error, two stages
module orfd_front import orfd_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int RAD_W    = 36
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [VEL_W-1:0]    velocity,
    input  logic [POS_BITS-1:0] x_now,
    input  logic [POS_BITS-1:0] y_now,
    input  logic [HEAD_W-1:0]   heading_now,
    input  logic [POS_BITS-1:0] x_target,
    input  logic [POS_BITS-1:0] y_target,
    input  logic [HEAD_W-1:0]   heading_target,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RAD_W-1:0]    out_rad,
    output side_t               out_side
);
    localparam int DIF_W = POS_BITS + 1;
    localparam int SQ_W  = 2 * DIF_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int PROD_W = ERR_W + 7 + 13;

    logic               a_valid_reg, b_valid_reg;
    logic               a_ready, b_ready;
    logic [DIF_W-1:0]   adx_reg, ady_reg, adx_next, ady_next;
    side_t              a_side_reg, a_side_next, b_side_reg;
    logic [RAD_W-1:0]   rad_reg, rad_next;

    logic signed [DIF_W-1:0] dx, dy;
    logic [HEAD_W-1:0]  hn, ht, herr, hchoice;
    logic [ERR_W-1:0]   err;
    logic [PROD_W-1:0]  rot_prod;
    logic [SQ_W-1:0]    sqx, sqy;
    logic [SUM_W-1:0]   sum;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    // stage a: absolute differences and heading error
    always_comb begin
        dx = $signed({x_target[POS_BITS-1], x_target}) - $signed({x_now[POS_BITS-1], x_now});
        dy = $signed({y_target[POS_BITS-1], y_target}) - $signed({y_now[POS_BITS-1], y_now});
        adx_next = dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
        ady_next = dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
        hn = heading_norm(heading_now);
        ht = heading_norm(heading_target);
        herr = (ht >= hn) ? ht - hn : hn - ht;
        if (herr > HALF_TURN) begin
            herr = FULL_TURN - herr;
        end
        err = herr[ERR_W-1:0];
        // wrapped signed difference, cw when it lands in the upper half turn
        hchoice = (ht >= hn) ? ht - hn : ht + FULL_TURN - hn;
        rot_prod = PROD_W'(err) * PROD_W'(ROT_GAIN) * PROD_W'(DIV100_MUL);
        a_side_next.kind      = kind;
        a_side_next.velocity  = velocity;
        a_side_next.err       = err;
        a_side_next.rot_extra = rot_prod[DIV100_SH +: ERR_W];
        a_side_next.cw        = (hchoice >= HALF_TURN);
    end

    // stage b: squares and their sum, pinned at all ones above 64 bits
    always_comb begin
        sqx = SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy = SQ_W'(ady_reg) * SQ_W'(ady_reg);
        sum = SUM_W'(sqx) + SUM_W'(sqy);
    end

    generate
        if (SUM_W > 64) begin : g_sat
            assign rad_next = (|sum[SUM_W-1:64]) ? {RAD_W{1'b1}} : RAD_W'(sum[63:0]);
        end else begin : g_nosat
            assign rad_next = RAD_W'(sum);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            adx_reg    <= adx_next;
            ady_reg    <= ady_next;
            a_side_reg <= a_side_next;
        end
        if (b_ready) begin
            rad_reg    <= rad_next;
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_rad   = rad_reg;
    assign out_side  = b_side_reg;

endmodule

FILE: rtl/orfd_root_cell.sv
// one cell of the square root chain: settles one root bit per request
module orfd_root_cell import orfd_pkg::*; #(
    parameter int RAD_W = 36
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RAD_W/2+1:0]   in_rem,
    input  logic [RAD_W/2-1:0]   in_root,
    input  logic [RAD_W-1:0]     in_rad,
    input  side_t                in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RAD_W/2+1:0]   out_rem,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [RAD_W-1:0]     out_rad,
    output side_t                out_side
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CMP_W  = REM_W + 2;

    logic               valid_reg;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    side_t              side_reg;

    logic [CMP_W-1:0]   rem_sh, trial, diff;
    logic               ge;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        rem_sh    = {in_rem, in_rad[RAD_W-1 -: 2]};
        trial     = {2'b00, in_root, 2'b01};
        ge        = (rem_sh >= trial);
        diff      = rem_sh - trial;
        rem_next  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_next = {in_root[ROOT_W-2:0], ge};
        rad_next  = {in_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;
    assign out_side  = side_reg;

endmodule

FILE: rtl/orfd_decide.sv
// back end: picks the motion, sets wheel modes and duties, holds the result
module orfd_decide import orfd_pkg::*; #(
    parameter int ROOT_W    = 18,
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ROOT_W-1:0]    root_dist,
    input  side_t                in_side,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((3*(MODE_W+DUTY_BITS)+7)/8)*8-1:0] m_tdata,
    output logic [ACT_W-1:0]     m_tuser
);
    localparam int WHEEL_W = MODE_W + DUTY_BITS;
    localparam int DATA_W  = ((3 * WHEEL_W + 7) / 8) * 8;
    localparam int CMP_W   = (ROOT_W > 16) ? ROOT_W : 16;
    localparam int DC_W    = DIST_CLAMP_W;
    localparam int FP_W    = DC_W + 1 + 11;
    localparam logic [DC_W-1:0] DC_MAX = {DC_W{1'b1}};

    logic                valid_reg;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [ACT_W-1:0]    act_reg, act_next;

    logic                far, rot;
    logic [DC_W-1:0]     dc;
    logic [FP_W-1:0]     fwd_prod;
    logic [8:0]          fwd_extra, rot_duty, fwd_duty, duty9;
    logic [DUTY_BITS-1:0] duty;
    logic [MODE_W-1:0]   m1, m2, m3;
    logic [DUTY_BITS-1:0] d1, d2, d3;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        far = (CMP_W'(root_dist) > CMP_W'(cfg.dist_thr));
        rot = (in_side.err > cfg.ang_thr) && far;

        rot_duty = 9'(cfg.base) + 9'(in_side.rot_extra);
        if (rot_duty > 9'(cfg.rot_cap)) begin
            rot_duty = 9'(cfg.rot_cap);
        end

        // large distances all saturate, so only the low range is divided
        dc = (root_dist > ROOT_W'(DC_MAX)) ? DC_MAX : root_dist[DC_W-1:0];
        fwd_prod  = FP_W'({dc, 1'b0}) * FP_W'(DIV5_MUL);
        fwd_extra = 9'(fwd_prod[FP_W-1:DIV5_SH]);
        if (fwd_extra > 9'(cfg.fwd_cap)) begin
            fwd_extra = 9'(cfg.fwd_cap);
        end
        fwd_duty = 9'(cfg.base) + fwd_extra;
        if (fwd_duty > 9'(cfg.fwd_cap)) begin
            fwd_duty = 9'(cfg.fwd_cap);
        end

        act_next = ACT_STOP;
        duty9    = '0;
        unique case (in_side.kind)
            KIND_FEEDBACK: begin
                if (rot) begin
                    act_next = in_side.cw ? ACT_CW : ACT_CCW;
                    duty9    = rot_duty;
                end else if (far) begin
                    act_next = ACT_FWD;
                    duty9    = fwd_duty;
                end
            end
            KIND_FWD: begin
                act_next = ACT_FWD;
                duty9    = 9'(in_side.velocity);
            end
            KIND_CCW: begin
                act_next = ACT_CCW;
                duty9    = 9'(in_side.velocity);
            end
            KIND_CW: begin
                act_next = ACT_CW;
                duty9    = 9'(in_side.velocity);
            end
            default: begin
                act_next = ACT_STOP;
            end
        endcase
        duty = DUTY_BITS'(duty9);

        m1 = MODE_BRAKE; m2 = MODE_BRAKE; m3 = MODE_BRAKE;
        d1 = '0; d2 = '0; d3 = '0;
        unique case (act_next)
            ACT_FWD: begin
                m1 = MODE_FWD; d1 = duty;
                m2 = MODE_REV; d2 = duty;
            end
            ACT_CCW: begin
                m1 = MODE_FWD; m2 = MODE_FWD; m3 = MODE_FWD;
                d1 = duty; d2 = duty; d3 = duty;
            end
            ACT_CW: begin
                m1 = MODE_REV; m2 = MODE_REV; m3 = MODE_REV;
                d1 = duty; d2 = duty; d3 = duty;
            end
            default: begin
                m1 = MODE_BRAKE;
            end
        endcase
        data_next = DATA_W'({d3, m3, d2, m2, d1, m1});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
            act_reg  <= act_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = act_reg;

endmodule

FILE: rtl/omni_robot_feedback_drive_core.sv
// top level of the omni robot drive core: front end, root chain, decision stage
//
// requests come in on the s_ stream: s_tuser holds the command kind, s_tdata the
// velocity, both positions and both headings. every request gives exactly one
// result on the m_ stream: three wheel modes and duties in m_tdata, the chosen
// action in m_tuser.
// the pipeline has two front stages (differences, then squares), one root cell
// per root bit and one output register.
// throughput is one request per cycle while m_tready is high; every stage has
// its own valid bit and takes new data whenever it is empty or its neighbor
// moves, so empty slots close up and a new request is taken while a finished
// result waits. when m_tready is low the output register holds its result and
// the chain fills up behind it; s_tready falls only when every stage is occupied.
// the config port writes one of the five registers on any cycle with cfg_wr_en
// high; write only while no request is in flight.
// reset (aresetn low, synchronous) empties all stages, dropping any request in
// flight, and loads the register defaults.
module omni_robot_feedback_drive_core import orfd_pkg::*; #(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // velocity, x_now, y_now, heading_now, x_target, y_target, heading_target
    input  logic [((VEL_W+4*POS_BITS+2*HEAD_W+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic [KIND_W-1:0] s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // wheel1_mode, wheel1_duty, wheel2_mode, wheel2_duty, wheel3_mode, wheel3_duty
    output logic [((3*(MODE_W+DUTY_BITS)+7)/8)*8-1:0] m_tdata,
    // action
    output logic [ACT_W-1:0] m_tuser
);
    // squared distance width, pinned to 64 bits, rounded up to whole root digits
    localparam int SUM_W     = 2 * (POS_BITS + 1) + 1;
    localparam int RAD_W_RAW = (SUM_W > 64) ? 64 : SUM_W;
    localparam int RAD_W     = RAD_W_RAW + (RAD_W_RAW % 2);
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;

    // tdata field offsets
    localparam int OFS_XN = VEL_W;
    localparam int OFS_YN = OFS_XN + POS_BITS;
    localparam int OFS_HN = OFS_YN + POS_BITS;
    localparam int OFS_XT = OFS_HN + HEAD_W;
    localparam int OFS_YT = OFS_XT + POS_BITS;
    localparam int OFS_HT = OFS_YT + POS_BITS;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dist_thr <= DIST_THR_RST;
            cfg_reg.ang_thr  <= ANG_THR_RST;
            cfg_reg.base     <= BASE_RST;
            cfg_reg.rot_cap  <= ROT_CAP_RST;
            cfg_reg.fwd_cap  <= FWD_CAP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIST_THR: cfg_reg.dist_thr <= cfg_wdata;
                REG_ANG_THR:  cfg_reg.ang_thr  <= cfg_wdata[7:0];
                REG_BASE:     cfg_reg.base     <= cfg_wdata[7:0];
                REG_ROT_CAP:  cfg_reg.rot_cap  <= cfg_wdata[7:0];
                REG_FWD_CAP:  cfg_reg.fwd_cap  <= cfg_wdata[7:0];
                default: begin
                    // writes past the register list are dropped
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // chain links: entry 0 is the front end output, entry ROOT_W the last cell
    logic              lk_valid [ROOT_W+1];
    logic              lk_ready [ROOT_W+1];
    logic [REM_W-1:0]  lk_rem   [ROOT_W+1];
    logic [ROOT_W-1:0] lk_root  [ROOT_W+1];
    logic [RAD_W-1:0]  lk_rad   [ROOT_W+1];
    side_t             lk_side  [ROOT_W+1];

    assign lk_rem[0]  = '0;
    assign lk_root[0] = '0;

    orfd_front #(
        .POS_BITS (POS_BITS),
        .RAD_W    (RAD_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .kind           (s_tuser),
        .velocity       (s_tdata[VEL_W-1:0]),
        .x_now          (s_tdata[OFS_XN +: POS_BITS]),
        .y_now          (s_tdata[OFS_YN +: POS_BITS]),
        .heading_now    (s_tdata[OFS_HN +: HEAD_W]),
        .x_target       (s_tdata[OFS_XT +: POS_BITS]),
        .y_target       (s_tdata[OFS_YT +: POS_BITS]),
        .heading_target (s_tdata[OFS_HT +: HEAD_W]),
        .out_valid      (lk_valid[0]),
        .out_ready      (lk_ready[0]),
        .out_rad        (lk_rad[0]),
        .out_side       (lk_side[0])
    );

    // one cell per root bit, most significant first
    for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
        orfd_root_cell #(
            .RAD_W (RAD_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lk_valid[i]),
            .in_ready  (lk_ready[i]),
            .in_rem    (lk_rem[i]),
            .in_root   (lk_root[i]),
            .in_rad    (lk_rad[i]),
            .in_side   (lk_side[i]),
            .out_valid (lk_valid[i+1]),
            .out_ready (lk_ready[i+1]),
            .out_rem   (lk_rem[i+1]),
            .out_root  (lk_root[i+1]),
            .out_rad   (lk_rad[i+1]),
            .out_side  (lk_side[i+1])
        );
    end

    orfd_decide #(
        .ROOT_W    (ROOT_W),
        .DUTY_BITS (DUTY_BITS)
    ) u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (lk_valid[ROOT_W]),
        .in_ready  (lk_ready[ROOT_W]),
        .root_dist (lk_root[ROOT_W]),
        .in_side   (lk_side[ROOT_W]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/orfd_checker.sv
// port-level checks of the drive core and their bind
`include "omni_robot_feedback_drive_core_assert.svh"

module orfd_checker import orfd_pkg::*; #(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [((3*(MODE_W+DUTY_BITS)+7)/8)*8-1:0] m_tdata,
    input logic [ACT_W-1:0] m_tuser
);
    localparam int WHEEL_W = MODE_W + DUTY_BITS;

    logic [MODE_W-1:0]    m1, m2, m3;
    logic [DUTY_BITS-1:0] d1, d2, d3;

    assign m1 = m_tdata[0 +: MODE_W];
    assign d1 = m_tdata[MODE_W +: DUTY_BITS];
    assign m2 = m_tdata[WHEEL_W +: MODE_W];
    assign d2 = m_tdata[WHEEL_W + MODE_W +: DUTY_BITS];
    assign m3 = m_tdata[2*WHEEL_W +: MODE_W];
    assign d3 = m_tdata[2*WHEEL_W + MODE_W +: DUTY_BITS];

    // a stalled result holds
    `ORFD_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // stop brakes every wheel at zero duty
    `ORFD_ASSERT_IMP(a_stop, m_tvalid && m_tuser == ACT_STOP, m1 == MODE_BRAKE && m2 == MODE_BRAKE && m3 == MODE_BRAKE && d1 == '0 && d2 == '0 && d3 == '0, "stop without full brake")

    // forward drives wheels one and two against each other and brakes wheel three
    `ORFD_ASSERT_IMP(a_fwd, m_tvalid && m_tuser == ACT_FWD, m1 == MODE_FWD && m2 == MODE_REV && m3 == MODE_BRAKE && d1 == d2 && d3 == '0, "forward wheel pattern wrong")

    // rotation turns all wheels the same way at one duty
    `ORFD_ASSERT_IMP(a_rot, m_tvalid && (m_tuser == ACT_CW || m_tuser == ACT_CCW), m1 == m2 && m2 == m3 && m1 != MODE_BRAKE && d1 == d2 && d2 == d3, "rotate wheel pattern wrong")

endmodule

bind omni_robot_feedback_drive_core orfd_checker #(
    .POS_BITS  (POS_BITS),
    .DUTY_BITS (DUTY_BITS)
) u_orfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
